// ===== design/riscv_subset_pipeline_core_top_macros.svh =====
// Assertion macros shared by the checker of the pipeline core.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef RISCV_SUBSET_PIPELINE_CORE_TOP_MACROS_SVH
`define RISCV_SUBSET_PIPELINE_CORE_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset
`define RSPC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rspc checker: same-cycle property failed");

// Next-cycle implication, disabled in reset
`define RSPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rspc checker: next-cycle property failed");

`endif

// ===== design/rspc_pkg.sv =====
// Package of the RV32I subset pipeline core: opcodes, field widths,
// stage record types and the immediate sign extension. No dependencies.
package rspc_pkg;

    localparam int XLEN       = 32;
    localparam int REG_AW     = 5;
    localparam int NUM_REGS   = 32;
    localparam int IDX_W      = 10;
    localparam int HIST_DEPTH = 3;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 88;

    // Opcodes and function codes
    localparam logic [6:0] OPC_BUBBLE = 7'b0000000;
    localparam logic [6:0] OPC_RTYPE  = 7'b0110011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] F7_SUB     = 7'b0100000;
    localparam logic [2:0] F3_AND     = 3'b111;
    localparam logic [2:0] F3_OR      = 3'b110;

    // Register write-back record
    typedef struct packed {
        logic              wr;
        logic [REG_AW-1:0] rd;
        logic [XLEN-1:0]   value;
    } wb_t;

    // One result beat
    typedef struct packed {
        logic              is_bubble;
        logic              reg_write;
        logic [REG_AW-1:0] dest_reg;
        logic [XLEN-1:0]   dest_value;
        logic              store_write;
        logic [IDX_W-1:0]  mem_index;
        logic [XLEN-1:0]   store_value;
    } result_t;

    function automatic logic [XLEN-1:0] sext12(input logic [11:0] v);
        return {{(XLEN-12){v[11]}}, v};
    endfunction

endpackage

// ===== design/rspc_ram.sv =====
// Generic single-clock RAM: one write port, one registered read port.
// A read of the address being written returns the new word. No dependencies.
module rspc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, new data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata <= wdata;
            end
            else
            begin
                rdata <= mem[raddr];
            end
        end
    end

endmodule

// ===== design/riscv_subset_pipeline_core_top.sv =====
// RV32I subset pipeline core: one instruction beat in, one result beat out.
// Depends on rspc_pkg and rspc_ram.
//
// Usage
//   s_* channel: one 32-bit instruction word per beat; opcode zero is a bubble.
//   m_* channel: one result beat per instruction, in order. m_tuser carries
//   the bubble flag; m_tdata carries the register write and store report.
//   A beat goes through the stage-1 and stage-2 registers into the output buffer.
//   Throughput: one instruction per clock while s_tready is high. Register
//   operands come from a two-read-port register file RAM (two copies) and a
//   three-entry history of recent results; lw and sw use one data memory
//   RAM addressed in stage 1. A register read sees the writes of instructions
//   at least WRITEBACK_DELAY+1 beats earlier, whatever the gaps between beats.
//   Reset: the pipeline empties and the data memory is zeroed by a pass over
//   all DATA_WORDS words, one word per cycle; s_tready stays low meanwhile.
//   Stall: results queue in a two-entry output buffer; the pipeline advances
//   while that buffer has room, so input is still taken while one result
//   waits, and the whole pipeline holds once two results wait.
module riscv_subset_pipeline_core_top #(
    parameter int DATA_WORDS      = 1024,
    parameter int WRITEBACK_DELAY = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rspc_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] instruction_word
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] reg_write, [5:1] dest_reg, [37:6] dest_value, [38] store_write,
    // [48:39] mem_index, [80:49] store_value, [87:81] zero
    output logic [rspc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [0:0]                    m_tuser   // [0] is_bubble
);

    localparam int DmAw = $clog2(DATA_WORDS);
    localparam int ModW = (DmAw > rspc_pkg::IDX_W) ? DmAw : rspc_pkg::IDX_W;
    localparam int PadW = rspc_pkg::M_TDATA_W - 81;

    // Pipeline control
    logic adv;
    logic clearing_reg, clearing_next;
    logic [DmAw-1:0] clr_addr_reg, clr_addr_next;

    // Stage 1: decode and execute
    logic                       s1_valid_reg;
    logic [rspc_pkg::XLEN-1:0]  s1_instr_reg;
    logic [rspc_pkg::XLEN-1:0]  rf1_rdata, rf2_rdata;
    logic [rspc_pkg::NUM_REGS-1:0] rf_valid_reg;
    rspc_pkg::wb_t              hist_reg [rspc_pkg::HIST_DEPTH];

    logic [6:0]                 opc, f7;
    logic [2:0]                 f3;
    logic [rspc_pkg::REG_AW-1:0] rd, rs1, rs2;
    logic                       is_store, is_load, is_rtype, is_alu, is_bub, wr;
    logic [rspc_pkg::XLEN-1:0]  op_a, op_b, imm_i, imm_s, alu_b, alu_out, addr_sum;
    logic [rspc_pkg::IDX_W-1:0] idx;
    logic [ModW-1:0]            mod_val;
    logic [DmAw-1:0]            dm_addr;
    rspc_pkg::result_t          s1_res;

    // Stage 2: load data and result
    logic                       s2_valid_reg;
    rspc_pkg::result_t          s2_res_reg;
    logic                       s2_load_reg;
    logic [rspc_pkg::XLEN-1:0]  dm_rdata, s2_value;
    rspc_pkg::result_t          s2_out;

    // Output buffer
    rspc_pkg::result_t          fifo_reg [2];
    logic                       wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                 count_reg, count_next;
    logic                       push, pop;
    rspc_pkg::result_t          head;

    // Memory ports
    logic                       rf_we;
    logic                       dm_we;
    logic [DmAw-1:0]            dm_waddr;
    logic [rspc_pkg::XLEN-1:0]  dm_wdata;

    // Advance the whole pipeline while the output buffer has room
    assign adv      = !clearing_reg && (count_reg != 2'd2);
    assign s_tready = adv;
    assign push     = adv && s2_valid_reg;
    assign pop      = m_tvalid && m_tready;

    // Register file: two copies for two read ports, written from the history tail
    assign rf_we = push && hist_reg[rspc_pkg::HIST_DEPTH-1].wr;

    rspc_ram #(.WIDTH(rspc_pkg::XLEN), .DEPTH(rspc_pkg::NUM_REGS)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (hist_reg[rspc_pkg::HIST_DEPTH-1].rd),
        .wdata (hist_reg[rspc_pkg::HIST_DEPTH-1].value),
        .re    (adv),
        .raddr (s_tdata[19:15]),
        .rdata (rf1_rdata)
    );

    rspc_ram #(.WIDTH(rspc_pkg::XLEN), .DEPTH(rspc_pkg::NUM_REGS)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (hist_reg[rspc_pkg::HIST_DEPTH-1].rd),
        .wdata (hist_reg[rspc_pkg::HIST_DEPTH-1].value),
        .re    (adv),
        .raddr (s_tdata[24:20]),
        .rdata (rf2_rdata)
    );

    // Field split
    assign opc = s1_instr_reg[6:0];
    assign rd  = s1_instr_reg[11:7];
    assign f3  = s1_instr_reg[14:12];
    assign rs1 = s1_instr_reg[19:15];
    assign rs2 = s1_instr_reg[24:20];
    assign f7  = s1_instr_reg[31:25];

    assign imm_i = rspc_pkg::sext12(s1_instr_reg[31:20]);
    assign imm_s = rspc_pkg::sext12({s1_instr_reg[31:25], s1_instr_reg[11:7]});

    // Stage-2 word: loaded data or ALU result
    assign s2_value = s2_load_reg ? dm_rdata : s2_res_reg.dest_value;

    // Operand select: file, then visible history entries, newest last
    always_comb
    begin
        op_a = rf_valid_reg[rs1] ? rf1_rdata : '0;
        op_b = rf_valid_reg[rs2] ? rf2_rdata : '0;
        for (int j = rspc_pkg::HIST_DEPTH - 1; j >= 0; j--)
        begin
            if ((j + 1 + int'(s2_valid_reg)) > WRITEBACK_DELAY)
            begin
                if (hist_reg[j].wr && (hist_reg[j].rd == rs1))
                begin
                    op_a = hist_reg[j].value;
                end
                if (hist_reg[j].wr && (hist_reg[j].rd == rs2))
                begin
                    op_b = hist_reg[j].value;
                end
            end
        end
        // immediately previous instruction, only without write-back delay
        if ((WRITEBACK_DELAY == 0) && s2_valid_reg && s2_res_reg.reg_write)
        begin
            if (s2_res_reg.dest_reg == rs1)
            begin
                op_a = s2_value;
            end
            if (s2_res_reg.dest_reg == rs2)
            begin
                op_b = s2_value;
            end
        end
        if (rs1 == '0)
        begin
            op_a = '0;
        end
        if (rs2 == '0)
        begin
            op_b = '0;
        end
    end

    // Decode
    always_comb
    begin
        is_bub   = 1'b0;
        is_store = 1'b0;
        is_load  = 1'b0;
        is_rtype = 1'b0;
        is_alu   = 1'b0;
        case (opc)
            rspc_pkg::OPC_BUBBLE: is_bub   = 1'b1;
            rspc_pkg::OPC_STORE:  is_store = 1'b1;
            rspc_pkg::OPC_LOAD:   is_load  = 1'b1;
            rspc_pkg::OPC_RTYPE:  is_rtype = 1'b1;
            default:              is_alu   = 1'b1;
        endcase
    end

    assign wr = (is_load || is_rtype || is_alu) && (rd != '0);

    // ALU
    assign alu_b = is_rtype ? op_b : imm_i;
    always_comb
    begin
        case (f3)
            rspc_pkg::F3_AND: alu_out = op_a & alu_b;
            rspc_pkg::F3_OR:  alu_out = op_a | alu_b;
            default:
            begin
                if (is_rtype && (f7 == rspc_pkg::F7_SUB))
                begin
                    alu_out = op_a - alu_b;
                end
                else
                begin
                    alu_out = op_a + alu_b;
                end
            end
        endcase
    end

    // Memory index and its reduction to the data memory depth
    assign addr_sum = op_a + (is_store ? imm_s : imm_i);
    assign idx      = addr_sum[rspc_pkg::IDX_W-1:0];

    always_comb
    begin
        mod_val = ModW'(idx);
        for (int b = 5; b >= 0; b--)
        begin
            if ((DATA_WORDS << b) < (1 << rspc_pkg::IDX_W))
            begin
                if (mod_val >= ModW'(DATA_WORDS << b))
                begin
                    mod_val = mod_val - ModW'(DATA_WORDS << b);
                end
            end
        end
    end
    assign dm_addr = mod_val[DmAw-1:0];

    // Stage-1 result record
    always_comb
    begin
        s1_res             = '0;
        s1_res.is_bubble   = is_bub;
        s1_res.reg_write   = wr;
        s1_res.dest_reg    = wr ? rd : '0;
        s1_res.dest_value  = (wr && !is_load) ? alu_out : '0;
        s1_res.store_write = is_store;
        s1_res.mem_index   = (is_load || is_store) ? idx : '0;
        s1_res.store_value = is_store ? op_b : '0;
    end

    // Data memory: clearing pass after reset, then stores from stage 1
    assign dm_we    = clearing_reg || (adv && s1_valid_reg && is_store);
    assign dm_waddr = clearing_reg ? clr_addr_reg : dm_addr;
    assign dm_wdata = clearing_reg ? '0 : op_b;

    rspc_ram #(.WIDTH(rspc_pkg::XLEN), .DEPTH(DATA_WORDS)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (adv),
        .raddr (dm_addr),
        .rdata (dm_rdata)
    );

    // Clearing pass sequencing
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            if (clr_addr_reg == DmAw'(DATA_WORDS - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + DmAw'(1);
            end
        end
    end

    // Final stage-2 beat
    always_comb
    begin
        s2_out            = s2_res_reg;
        s2_out.dest_value = s2_value;
    end

    // Output buffer
    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {PadW'(0), head.store_value, head.mem_index, head.store_write,
                       head.dest_value, head.dest_reg, head.reg_write};
    assign m_tuser  = head.is_bubble;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            rf_valid_reg <= '0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            count_reg    <= 2'd0;
            for (int j = 0; j < rspc_pkg::HIST_DEPTH; j++)
            begin
                hist_reg[j] <= '0;
            end
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
            if (adv)
            begin
                s1_valid_reg <= s_tvalid;
                s2_valid_reg <= s1_valid_reg;
            end
            if (push)
            begin
                wr_ptr_reg  <= ~wr_ptr_reg;
                hist_reg[0] <= '{wr: s2_res_reg.reg_write, rd: s2_res_reg.dest_reg,
                                 value: s2_value};
                for (int j = 1; j < rspc_pkg::HIST_DEPTH; j++)
                begin
                    hist_reg[j] <= hist_reg[j-1];
                end
            end
            if (rf_we)
            begin
                rf_valid_reg[hist_reg[rspc_pkg::HIST_DEPTH-1].rd] <= 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_instr_reg <= s_tdata;
            s2_res_reg   <= s1_res;
            s2_load_reg  <= is_load && wr;
        end
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= s2_out;
        end
    end

endmodule

// ===== design/rspc_checker.sv =====
// Port-level checker for the pipeline core, bound to the top level.
// Depends on rspc_pkg and riscv_subset_pipeline_core_top_macros.svh.
`include "riscv_subset_pipeline_core_top_macros.svh"

module rspc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [rspc_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rspc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser
);

    // A waiting result beat is not withdrawn
    `RSPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // A bubble reports nothing
    `RSPC_ASSERT_SAME(a_bubble_empty, m_tvalid && m_tuser[0], m_tdata == '0)

    // No register write: destination fields are zero
    `RSPC_ASSERT_SAME(a_no_write_zero, m_tvalid && !m_tdata[0], m_tdata[37:1] == '0)

    // A register write never targets x0 and never comes with a store
    `RSPC_ASSERT_SAME(a_write_sane, m_tvalid && m_tdata[0],
                      (m_tdata[5:1] != 5'd0) && !m_tdata[38] && (m_tdata[80:49] == '0))

    // A waiting result beat keeps its payload
    `RSPC_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

endmodule

bind riscv_subset_pipeline_core_top rspc_checker u_rspc_checker (.*);
